[hdl/lpr_pkg.sv]
package lpr_pkg;

   // Default sizes of the stores and the sample path
   localparam int MAX_FRAMES_DEF   = 65536;
   localparam int MAX_CHANNELS_DEF = 2;
   localparam int SAMPLE_BITS_DEF  = 24;

   // Fixed field widths
   localparam int OPCODE_W   = 3;
   localparam int ADDR_W     = 17;
   localparam int POS_W      = 17;
   localparam int GAIN_W     = 16;
   localparam int CHAN_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int FRAC_BITS  = 12;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);
   localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(1);

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_SAMPLE = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ARM    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SEEK   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_LOAD   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PLAY_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_LENGTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS     = 2'd3;

   typedef struct packed {
      logic             armed;
      logic             recording;
      logic             have_loop;
      logic [POS_W-1:0] position;
   } status_type;

endpackage

[hdl/lpr_req_if.sv]
interface lpr_req_if
   import lpr_pkg::*;
   #(parameter int SAMPLE_W = SAMPLE_BITS_DEF);

   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic signed [SAMPLE_W-1:0] in_sample;
   logic [ADDR_W-1:0]          clip_address;
   logic signed [SAMPLE_W-1:0] clip_word;
   logic [POS_W-1:0]           seek_frame;

   modport source (output valid, opcode, in_sample, clip_address, clip_word, seek_frame,
                   input ready);
   modport sink   (input valid, opcode, in_sample, clip_address, clip_word, seek_frame,
                   output ready);

endinterface

[hdl/lpr_rsp_if.sv]
interface lpr_rsp_if
   import lpr_pkg::*;
   #(parameter int SAMPLE_W = SAMPLE_BITS_DEF);

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample;
   logic                       armed;
   logic                       recording_now;
   logic                       loop_ready;
   logic [POS_W-1:0]           position_now;

   modport source (output valid, out_sample, armed, recording_now, loop_ready, position_now,
                   input ready);
   modport sink   (input valid, out_sample, armed, recording_now, loop_ready, position_now,
                   output ready);

endinterface

[hdl/loop_player_with_record.sv]
// Loop player with loop recording.
// req_ch takes one transaction per item: a sample, an arm, a seek, a clip word load
// or a clear. rsp_ch returns exactly one transaction per item, in order: the record
// flags, the play position after the item and the sample: live input + clip frame sum
// times gain + recorded loop, saturated, if playing, else the input; other items give 0.
// csr_* writes the play enable, gain, loop length and channel count registers; write
// them only while no item is in flight.
// A result passes through the registered stages s1, s2, s3 and the output queue.
// No new item is taken while the last one is in s1, as each frame needs two interleaved
// clip reads through the single port of the clip memory.
// A 3-entry output queue decouples the sides; ready drops once 3 items are
// outstanding, so a stalled receiver holds the block without loss.
// Reset sets the registers to their defaults and clears the flags, position and
// queue; the clip and loop memories keep their contents and need no clearing pass.
// Loads fill the clip memory, and recording fills the loop memory.
module loop_player_with_record
   import lpr_pkg::*;
   #(parameter int MAX_FRAMES   = MAX_FRAMES_DEF,
     parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
     parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF)
   (input  logic                  clock,
    input  logic                  reset,
    lpr_req_if.sink               req_ch,
    lpr_rsp_if.source             rsp_ch,
    input  logic                  csr_we,
    input  logic [CSR_IDX_W-1:0]  csr_index,
    input  logic [CSR_DATA_W-1:0] csr_data);

   localparam int SW         = SAMPLE_BITS;
   localparam int CLIP_WORDS = MAX_FRAMES * MAX_CHANNELS;
   localparam int CLIP_AW    = $clog2(CLIP_WORDS);
   localparam int LOOP_AW    = $clog2(MAX_FRAMES);
   localparam int LEN_LIM    = (MAX_FRAMES > 131071) ? 131071 : MAX_FRAMES;
   localparam int SUM_W      = SW + 1;
   localparam int PROD_W     = SUM_W + GAIN_W + 1;
   localparam int Q_DEPTH    = 3;

   typedef enum logic [1:0] {MODE_ZERO, MODE_PASS, MODE_MIX} mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       ch2;
      logic       use_loop;
      status_type st;
   } ctx_type;

   // Configuration registers
   logic                 play_en_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [POS_W-1:0]     loop_len_ff;
   logic [CHAN_W-1:0]    chan_cnt_ff;

   // Architectural state
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 arm_ff, arm_in;
   logic                 rec_ff, rec_in;
   logic                 have_ff, have_in;

   // Memories
   logic signed [SW-1:0] clip_mem [CLIP_WORDS];
   logic signed [SW-1:0] loop_mem [MAX_FRAMES];
   logic signed [SW-1:0] clip_q_ff;
   logic signed [SW-1:0] loop_q_ff;

   // Pipeline
   logic                 s1_vld_ff, s2_vld_ff, s3_vld_ff;
   ctx_type              s1_ctx_ff, s2_ctx_ff, s3_ctx_ff, ctx_in;
   logic signed [SW-1:0] s1_smp_ff, s2_smp_ff, s3_smp_ff;
   logic [CLIP_AW-1:0]   s1_addr1_ff;
   logic signed [SW-1:0] s2_word0_ff, s2_loop_ff, s3_loop_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;

   // Output queue
   logic signed [SW-1:0] q_smp_ff [Q_DEPTH];
   status_type           q_st_ff  [Q_DEPTH];
   logic [1:0]           q_wr_ff, q_rd_ff, q_cnt_ff, outst_ff;

   // Combinational
   logic                 accept, pop, playing, wrap, clip_we, loop_we, clip_in_range;
   logic [POS_W-1:0]     len_c, p_c;
   logic [CLIP_AW-1:0]   addr0_c, clip_addr_c;
   logic signed [SUM_W-1:0]  sum_c;
   logic signed [PROD_W-1:0] prod_c, rnd_c, total_c;
   logic signed [SW-1:0] result_c;

   assign req_ch.ready = !s1_vld_ff && (outst_ff != 2'(Q_DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   assign len_c   = (loop_len_ff > POS_W'(LEN_LIM)) ? POS_W'(LEN_LIM) : loop_len_ff;
   assign playing = play_en_ff && (len_c != '0);
   assign wrap    = pos_ff >= len_c;
   assign p_c     = wrap ? '0 : pos_ff;
   assign clip_in_range = (CLIP_WORDS > 131071) || (32'(req_ch.clip_address) < CLIP_WORDS);

   // Item decode and state update
   always_comb begin
      pos_in  = pos_ff;
      arm_in  = arm_ff;
      rec_in  = rec_ff;
      have_in = have_ff;
      clip_we = 1'b0;
      loop_we = 1'b0;
      ctx_in.mode     = MODE_ZERO;
      ctx_in.ch2      = (MAX_CHANNELS > 1) && (chan_cnt_ff >= CHAN_W'(2));
      ctx_in.use_loop = 1'b0;
      unique case (req_ch.opcode)
         OP_SAMPLE: begin
            if (!playing) begin
               ctx_in.mode = MODE_PASS;
            end else begin
               ctx_in.mode = MODE_MIX;
               if (wrap) begin
                  if (rec_ff) begin
                     rec_in  = 1'b0;
                     arm_in  = 1'b0;
                     have_in = 1'b1;
                  end else if (arm_ff) begin
                     rec_in = 1'b1;
                  end
               end
               loop_we         = rec_in;
               ctx_in.use_loop = have_in;
               pos_in          = p_c + POS_W'(1);
            end
         end
         OP_ARM: begin
            if (play_en_ff) begin
               arm_in  = 1'b1;
               have_in = 1'b0;
               rec_in  = 1'b0;
            end
         end
         OP_SEEK: begin
            pos_in = (req_ch.seek_frame > len_c) ? len_c : req_ch.seek_frame;
         end
         OP_LOAD: begin
            clip_we = clip_in_range;
         end
         OP_CLEAR: begin
            arm_in  = 1'b0;
            rec_in  = 1'b0;
            have_in = 1'b0;
            pos_in  = '0;
         end
         default: begin
         end
      endcase
      ctx_in.st.armed     = arm_in;
      ctx_in.st.recording = rec_in;
      ctx_in.st.have_loop = have_in;
      ctx_in.st.position  = pos_in;
   end

   assign addr0_c = ctx_in.ch2 ? CLIP_AW'({p_c, 1'b0}) : CLIP_AW'(p_c);
   // While an item is in s1, the clip is read at the word after its first address (second channel)
   assign clip_addr_c = s1_vld_ff ? s1_addr1_ff :
                        (req_ch.opcode == OP_LOAD) ? CLIP_AW'(req_ch.clip_address) : addr0_c;

   // Clip memory, single port
   always_ff @(posedge clock) begin
      if (accept && clip_we) begin
         clip_mem[clip_addr_c] <= req_ch.clip_word;
      end else begin
         clip_q_ff <= clip_mem[clip_addr_c];
      end
   end

   // Loop memory, single port; recording and loop playback never overlap
   always_ff @(posedge clock) begin
      if (accept && loop_we) begin
         loop_mem[LOOP_AW'(p_c)] <= req_ch.in_sample;
      end else if (accept) begin
         loop_q_ff <= loop_mem[LOOP_AW'(p_c)];
      end
   end

   // Mix arithmetic
   assign sum_c   = {s2_word0_ff[SW-1], s2_word0_ff}
                  + (s2_ctx_ff.ch2 ? {clip_q_ff[SW-1], clip_q_ff} : SUM_W'(0));
   assign prod_c  = sum_c * $signed({1'b0, gain_ff});
   assign rnd_c   = (s3_prod_ff + PROD_W'(2048)) >>> FRAC_BITS;
   assign total_c = rnd_c
                  + {{(PROD_W-SW){s3_smp_ff[SW-1]}}, s3_smp_ff}
                  + {{(PROD_W-SW){s3_loop_ff[SW-1]}}, s3_loop_ff};

   always_comb begin
      unique case (s3_ctx_ff.mode)
         MODE_PASS: result_c = s3_smp_ff;
         MODE_MIX: begin
            // Clamp when the upper bits do not all match the sign
            if (total_c[PROD_W-1:SW-1] == '0 || total_c[PROD_W-1:SW-1] == '1) begin
               result_c = total_c[SW-1:0];
            end else begin
               result_c = total_c[PROD_W-1] ? {1'b1, {(SW-1){1'b0}}}
                                            : {1'b0, {(SW-1){1'b1}}};
            end
         end
         default: result_c = '0;
      endcase
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctx_ff   <= ctx_in;
         s1_smp_ff   <= req_ch.in_sample;
         s1_addr1_ff <= addr0_c + CLIP_AW'(1);
      end
      if (s1_vld_ff) begin
         s2_ctx_ff   <= s1_ctx_ff;
         s2_smp_ff   <= s1_smp_ff;
         s2_word0_ff <= clip_q_ff;
         s2_loop_ff  <= loop_q_ff;
      end
      if (s2_vld_ff) begin
         s3_ctx_ff  <= s2_ctx_ff;
         s3_smp_ff  <= s2_smp_ff;
         s3_prod_ff <= prod_c;
         s3_loop_ff <= s2_ctx_ff.use_loop ? s2_loop_ff : '0;
      end
      if (s3_vld_ff) begin
         q_smp_ff[q_wr_ff] <= result_c;
         q_st_ff[q_wr_ff]  <= s3_ctx_ff.st;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         play_en_ff  <= 1'b0;
         gain_ff     <= GAIN_RESET;
         loop_len_ff <= '0;
         chan_cnt_ff <= CHAN_RESET;
         pos_ff      <= '0;
         arm_ff      <= 1'b0;
         rec_ff      <= 1'b0;
         have_ff     <= 1'b0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         q_wr_ff     <= '0;
         q_rd_ff     <= '0;
         q_cnt_ff    <= '0;
         outst_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_PLAY_ENABLE: play_en_ff  <= csr_data[0];
               REG_GAIN:        gain_ff     <= csr_data[GAIN_W-1:0];
               REG_LOOP_LENGTH: loop_len_ff <= csr_data[POS_W-1:0];
               REG_CHANNELS:    chan_cnt_ff <= csr_data[CHAN_W-1:0];
            endcase
         end
         if (accept) begin
            pos_ff  <= pos_in;
            arm_ff  <= arm_in;
            rec_ff  <= rec_in;
            have_ff <= have_in;
         end
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         if (s3_vld_ff) begin
            q_wr_ff <= (q_wr_ff == 2'(Q_DEPTH - 1)) ? '0 : q_wr_ff + 2'd1;
         end
         if (pop) begin
            q_rd_ff <= (q_rd_ff == 2'(Q_DEPTH - 1)) ? '0 : q_rd_ff + 2'd1;
         end
         q_cnt_ff <= q_cnt_ff + 2'(s3_vld_ff) - 2'(pop);
         outst_ff <= outst_ff + 2'(accept) - 2'(pop);
      end
   end

   assign rsp_ch.valid         = q_cnt_ff != '0;
   assign rsp_ch.out_sample    = q_smp_ff[q_rd_ff];
   assign rsp_ch.armed         = q_st_ff[q_rd_ff].armed;
   assign rsp_ch.recording_now = q_st_ff[q_rd_ff].recording;
   assign rsp_ch.loop_ready    = q_st_ff[q_rd_ff].have_loop;
   assign rsp_ch.position_now  = q_st_ff[q_rd_ff].position;

endmodule
